[src/hxs_pkg.sv]
// Shared types and constants for the HID report to XT scan code translator.
package hxs_pkg;

	// Key list layout: eight modifier usages, then up to six key slots
	localparam int NUM_MODS  = 8;
	localparam int NUM_SLOTS = 6;
	localparam int LIST_LEN  = NUM_MODS + NUM_SLOTS;
	localparam int IDX_W     = 4;
	localparam int IN_DATA_W = 80;

	localparam logic [7:0] MOD_BASE  = 8'hE0;
	localparam logic [7:0] BREAK_BIT = 8'h80;

	// Input item kinds carried on tuser
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	typedef logic [7:0] byte_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic load_we;
		logic scan_rd;
		logic advance;
		logic push_esc;
		logic push_low;
		logic flush;
	} hxs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic entry_skip;
		logic pos_last;
		logic code_skip;
		logic esc_nz;
		logic low_emit;
		logic can_push;
		logic hold_vld;
		logic out_free;
	} hxs_stat_t;

endpackage

[src/hxs_ctrl.sv]
// Sequencer for table loads and the release and press passes of a report.
module hxs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_type,
	output logic             in_ready,
	input  hxs_pkg::hxs_stat_t stat,
	output hxs_pkg::hxs_cmd_t  cmd
);
	import hxs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_LOOK  = 6'b000100,
		ST_ESC   = 6'b001000,
		ST_LOW   = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_type == REQ_REPORT) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (stat.entry_skip) begin
					cmd.advance = 1'b1;
					state_d     = stat.pos_last ? ST_FLUSH : ST_SCAN;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.code_skip) begin
					cmd.advance = 1'b1;
					state_d     = stat.pos_last ? ST_FLUSH : ST_SCAN;
				end else if (stat.esc_nz) begin
					state_d = ST_ESC;
				end else if (stat.low_emit) begin
					state_d = ST_LOW;
				end else begin
					// release of a code that already has its break bit, no escape
					cmd.advance = 1'b1;
					state_d     = stat.pos_last ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_ESC: begin
				if (stat.can_push) begin
					cmd.push_esc = 1'b1;
					if (stat.low_emit) begin
						state_d = ST_LOW;
					end else begin
						cmd.advance = 1'b1;
						state_d     = stat.pos_last ? ST_FLUSH : ST_SCAN;
					end
				end
			end
			ST_LOW: begin
				if (stat.can_push) begin
					cmd.push_low = 1'b1;
					cmd.advance  = 1'b1;
					state_d      = stat.pos_last ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_FLUSH: begin
				if (!stat.hold_vld || stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/hxs_datapath.sv]
// Key lists, translation table, match logic and output byte buffering.
module hxs_datapath #(
	parameter int KEY_SLOTS   = 6,
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hxs_pkg::IN_DATA_W-1:0]  in_data,
	input  hxs_pkg::hxs_cmd_t              cmd,
	output hxs_pkg::hxs_stat_t             stat,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [7:0]                     out_data,
	output logic                           out_last
);
	import hxs_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(LIST_LEN - 1);

	// Report registers
	byte_t cur_mods_q;
	byte_t cur_slots_q [NUM_SLOTS];
	byte_t prev_mods_q;
	byte_t prev_slots_q [NUM_SLOTS];

	// List position and per-entry pending marks of the new list
	logic                pass_q;
	logic [IDX_W-1:0]    idx_q;
	logic [LIST_LEN-1:0] pending_q;

	// Table and lookup result
	logic [15:0]          tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tbl_vld_q;
	logic [15:0]          rd_code_q;
	logic                 rd_vld_q;
	logic                 rng_ok_q;
	logic                 rel_q;

	// Output buffering: one byte held back to mark the last one
	byte_t hold_q;
	logic  hold_vld_q;
	byte_t out_q;
	logic  out_last_q;
	logic  out_vld_q;

	// Combinational list views
	byte_t               new_use [LIST_LEN];
	byte_t               old_use [LIST_LEN];
	logic [LIST_LEN-1:0] new_ok;
	logic [LIST_LEN-1:0] old_ok;
	logic [LIST_LEN-1:0] eq_vec;
	byte_t               cur_use;
	logic                cur_ok;
	logic                match;
	logic                use_in_rng;
	logic [15:0]         eff_code;
	byte_t               low_byte;
	byte_t               push_byte;
	logic                out_free;

	// Load fields
	byte_t       ld_index;
	logic [15:0] ld_code;
	assign ld_index = in_data[7:0];
	assign ld_code  = in_data[23:8];

	// Build old and new key lists
	always_comb begin
		logic chain_n;
		logic chain_o;
		chain_n = 1'b1;
		chain_o = 1'b1;
		for (int i = 0; i < NUM_MODS; i++) begin
			new_use[i] = MOD_BASE | 8'(i);
			old_use[i] = MOD_BASE | 8'(i);
			new_ok[i]  = cur_mods_q[i];
			old_ok[i]  = prev_mods_q[i];
		end
		for (int j = 0; j < NUM_SLOTS; j++) begin
			chain_n = chain_n && (cur_slots_q[j] != 8'h00) && (j < KEY_SLOTS);
			chain_o = chain_o && (prev_slots_q[j] != 8'h00) && (j < KEY_SLOTS);
			new_use[NUM_MODS + j] = cur_slots_q[j];
			old_use[NUM_MODS + j] = prev_slots_q[j];
			new_ok[NUM_MODS + j]  = chain_n;
			old_ok[NUM_MODS + j]  = chain_o;
		end
	end

	// Current entry and its match against still-pending new keys
	assign cur_use = pass_q ? new_use[idx_q] : old_use[idx_q];
	assign cur_ok  = pass_q ? (new_ok[idx_q] && pending_q[idx_q]) : old_ok[idx_q];

	always_comb begin
		for (int i = 0; i < LIST_LEN; i++) begin
			eq_vec[i] = new_ok[i] && (new_use[i] == cur_use);
		end
	end

	assign match      = |(eq_vec & pending_q);
	assign use_in_rng = {1'b0, cur_use} < 9'(TABLE_DEPTH);

	// Report capture, position counter and pending marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q    <= 1'b0;
			idx_q     <= '0;
			pending_q <= '0;
		end else if (cmd.start) begin
			pass_q    <= 1'b0;
			idx_q     <= '0;
			pending_q <= '1;
		end else if (cmd.advance) begin
			// old key still held: consume every new entry with this usage
			if (!pass_q && old_ok[idx_q] && match) begin
				pending_q <= pending_q & ~eq_vec;
			end
			if (idx_q == IDX_END) begin
				idx_q  <= '0;
				pass_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_mods_q <= in_data[31:24];
			for (int j = 0; j < NUM_SLOTS; j++) begin
				cur_slots_q[j] <= in_data[32 + 8*j +: 8];
			end
		end
	end

	// Previous report, committed at the end of a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				prev_slots_q[j] <= '0;
			end
		end else if (cmd.flush) begin
			prev_mods_q <= cur_mods_q;
			for (int j = 0; j < NUM_SLOTS; j++) begin
				prev_slots_q[j] <= cur_slots_q[j];
			end
		end
	end

	// Translation table memory
	always_ff @(posedge clk) begin
		if (cmd.load_we && ({1'b0, ld_index} < 9'(TABLE_DEPTH))) begin
			tbl_mem[ld_index[ADDR_W-1:0]] <= ld_code;
		end
		if (cmd.scan_rd && use_in_rng) begin
			rd_code_q <= tbl_mem[cur_use[ADDR_W-1:0]];
		end
		if (cmd.scan_rd) begin
			rel_q <= !pass_q;
		end
	end

	// Entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			rng_ok_q  <= 1'b0;
		end else begin
			if (cmd.load_we && ({1'b0, ld_index} < 9'(TABLE_DEPTH))) begin
				tbl_vld_q[ld_index[ADDR_W-1:0]] <= 1'b1;
			end
			if (cmd.scan_rd) begin
				rng_ok_q <= use_in_rng;
				rd_vld_q <= use_in_rng ? tbl_vld_q[cur_use[ADDR_W-1:0]] : 1'b0;
			end
		end
	end

	// Looked-up code and bytes to emit
	assign eff_code  = (rd_vld_q && rng_ok_q) ? rd_code_q : 16'h0000;
	assign low_byte  = rel_q ? (eff_code[7:0] | BREAK_BIT) : eff_code[7:0];
	assign push_byte = cmd.push_esc ? eff_code[15:8] : low_byte;
	assign out_free  = !out_vld_q || out_ready;

	// Hold and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.push_esc || cmd.push_low) begin
				hold_vld_q <= 1'b1;
				if (hold_vld_q) begin
					out_vld_q <= 1'b1;
				end else if (out_ready) begin
					out_vld_q <= 1'b0;
				end
			end else if (cmd.flush && hold_vld_q) begin
				hold_vld_q <= 1'b0;
				out_vld_q  <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_esc || cmd.push_low) begin
			hold_q <= push_byte;
			if (hold_vld_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.flush && hold_vld_q) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	// Status to the controller
	assign stat.entry_skip = !cur_ok || (!pass_q && match);
	assign stat.pos_last   = pass_q && (idx_q == IDX_END);
	assign stat.code_skip  = (eff_code == 16'h0000);
	assign stat.esc_nz     = (eff_code[15:8] != 8'h00);
	assign stat.low_emit   = !(rel_q && eff_code[7]);
	assign stat.can_push   = !hold_vld_q || out_free;
	assign stat.hold_vld   = hold_vld_q;
	assign stat.out_free   = out_free;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign out_last  = out_last_q;

endmodule

[src/hid_report_to_xt_scancodes.sv]
// Top level: HID boot keyboard reports to XT scan code set 1 byte stream.
//
//  channel  | dir | content
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tuser: req_type; tdata: table_index, table_code,
//           |     |   modifier_bits, slot_0..slot_5 (80 bits)
//  m_axis   | out | tdata: scan_byte; tlast: last_byte
//
// A load item is written while idle. A report, held by output stalls, walks every position
// of the two 14-entry key lists (old list for releases, then new list for presses), with
// a table lookup for each key that changed, a step per emitted byte, and a closing flush.
// The table valid bits clear at reset; no clearing pass.
// The last emitted byte waits in the output register while the next item is taken.
module hid_report_to_xt_scancodes #(
	parameter int KEY_SLOTS   = 6,
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // table_index, table_code, modifier_bits, slot_0..slot_5
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // scan_byte
	output logic        m_axis_tlast
);
	import hxs_pkg::*;

	hxs_cmd_t  cmd;
	hxs_stat_t stat;

	hxs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_type  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hxs_datapath #(
		.KEY_SLOTS   (KEY_SLOTS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[src/hxs_checker.sv]
// Port-level checks for the translator, bound to the top level.
module hxs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [79:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);
	import hxs_pkg::*;

	// A stalled output item stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// Non-final bytes only appear while a report is in progress
	a_busy_mid_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready in the middle of a report");

	// A load leaves the input ready, a report keeps the input closed
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD) |=> s_axis_tready)
		else $error("load item did not return to ready");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_REPORT) |=> !s_axis_tready)
		else $error("ready right after a report item");

endmodule

bind hid_report_to_xt_scancodes hxs_checker u_hxs_checker (.*);

[tb/tb_hid_report_to_xt_scancodes.sv]
// Self-checking testbench for the HID report to XT scan code translator.
`timescale 1ns / 1ps

module tb_hid_report_to_xt_scancodes;
	import hxs_pkg::*;

	localparam int TABLE_DEPTH    = 256;
	localparam int MAX_BYTES      = 40;
	localparam int TAIL_ITEMS     = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int PRESSURE_AT    = 40;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 83;

	// One input item as it goes onto the slave side
	typedef struct {
		logic                 kind;
		logic [IN_DATA_W-1:0] data;
	} hid_item_t;

	// One emitted scan code byte
	typedef struct {
		byte_t code;
		logic  is_last;
	} xt_byte_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
	logic                 s_axis_tuser  = REQ_LOAD;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tlast;

	hid_item_t hid_items_q[$];
	xt_byte_t  xt_bytes_due[$];
	byte_t     report_bytes[$];

	// Shadow state of the translator
	logic [15:0] xlat_table[TABLE_DEPTH];
	byte_t       last_mods;
	logic [47:0] last_slots;

	// Generator memory of the last queued report
	byte_t       gen_mods;
	logic [47:0] gen_slots;

	logic in_taken    = 1'b0;
	int   send_gap    = 0;
	int   stall_left  = 0;
	bit   stall_done  = 0;
	int   out_count   = 0;
	int   load_count  = 0;
	int   rep_count   = 0;
	int   err_count   = 0;
	int   idle_cycles = 0;

	hid_report_to_xt_scancodes dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Modifier usages from bit 0 up, then slots up to the first zero
	function automatic int key_list(input byte_t mods, input logic [47:0] slots,
			output logic [LIST_LEN*8-1:0] keys);
		int n;
		n = 0;
		keys = '0;
		for (int i = 0; i < NUM_MODS; i++) begin
			if (mods[i]) begin
				keys[n*8 +: 8] = MOD_BASE + byte_t'(i);
				n++;
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slots[i*8 +: 8] == 8'h00)
				break;
			keys[n*8 +: 8] = slots[i*8 +: 8];
			n++;
		end
		return n;
	endfunction

	// Bytes of one press or release
	function automatic void key_event(input byte_t usage, input logic press);
		logic [15:0] code;
		if (int'(usage) >= TABLE_DEPTH)
			return;
		code = xlat_table[usage];
		if (code == 16'h0000)
			return;
		if (code[15:8] != 8'h00)
			report_bytes.push_back(code[15:8]);
		if (press)
			report_bytes.push_back(code[7:0]);
		else if (!code[7])
			report_bytes.push_back(code[7:0] | BREAK_BIT);
	endfunction

	// Expected bytes of one accepted item
	function automatic void translate_item(input logic kind, input logic [IN_DATA_W-1:0] d);
		logic [LIST_LEN*8-1:0] old_keys, new_keys;
		logic [255:0]          held;
		int                    old_n, new_n, n;
		byte_t                 k;
		xt_byte_t              e;
		if (kind == REQ_LOAD) begin
			if (int'(d[7:0]) < TABLE_DEPTH)
				xlat_table[d[7:0]] = d[23:8];
			return;
		end
		old_n = key_list(last_mods, last_slots, old_keys);
		new_n = key_list(d[31:24], d[79:32], new_keys);
		held = '0;
		for (int i = 0; i < new_n; i++)
			held[new_keys[i*8 +: 8]] = 1'b1;
		report_bytes.delete();
		// Releases: old keys not matched by a held new key
		for (int i = 0; i < old_n; i++) begin
			k = old_keys[i*8 +: 8];
			if (held[k])
				held[k] = 1'b0;
			else
				key_event(k, 1'b0);
		end
		// Presses: new keys still marked
		for (int i = 0; i < new_n; i++) begin
			k = new_keys[i*8 +: 8];
			if (held[k])
				key_event(k, 1'b1);
		end
		last_mods  = d[31:24];
		last_slots = d[79:32];
		n = (report_bytes.size() > MAX_BYTES) ? MAX_BYTES : report_bytes.size();
		for (int i = 0; i < n; i++) begin
			e.code    = report_bytes[i];
			e.is_last = (i == n - 1);
			xt_bytes_due.push_back(e);
		end
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	// Unused fields of each item carry random bits
	task automatic push_load(input byte_t idx, input logic [15:0] code);
		hid_item_t it;
		it.kind = REQ_LOAD;
		it.data = {24'($urandom), 32'($urandom), code, idx};
		hid_items_q.push_back(it);
	endtask

	task automatic push_report(input byte_t mods, input logic [47:0] slots);
		hid_item_t it;
		it.kind = REQ_REPORT;
		it.data = {slots, mods, 16'($urandom), 8'($urandom)};
		gen_mods  = mods;
		gen_slots = slots;
		hid_items_q.push_back(it);
	endtask

	function automatic byte_t pick_key();
		return byte_t'(8'h04 + $urandom_range(0, 27));
	endfunction

	// Sender: holds an item until taken, random idle bursts until the tail
	always @(negedge clk) begin
		hid_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (hid_items_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (hid_items_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
				send_gap = $urandom_range(0, 4);
				s_axis_tvalid <= 1'b0;
			end else begin
				it = hid_items_q.pop_front();
				s_axis_tdata  <= it.data;
				s_axis_tuser  <= it.kind;
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: one long hold-off, otherwise short random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (!stall_done && out_count >= PRESSURE_AT) begin
			stall_done = 1;
			stall_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (hid_items_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: check emitted bytes, predict from accepted items, watchdog
	always @(posedge clk) begin
		xt_byte_t want;
		bit       moved;
		moved = 0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1;
				out_count++;
				if (xt_bytes_due.size() == 0) begin
					flag_error($sformatf("unexpected scan 0x%02h last %0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = xt_bytes_due.pop_front();
					if (m_axis_tdata !== want.code || m_axis_tlast !== want.is_last)
						flag_error($sformatf(
							"byte %0d: expected scan 0x%02h last %0b, got scan 0x%02h last %0b",
							out_count, want.code, want.is_last, m_axis_tdata, m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1;
				if (s_axis_tuser == REQ_LOAD)
					load_count++;
				else
					rep_count++;
				translate_item(s_axis_tuser, s_axis_tdata);
			end
		end
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int          r, n;
		byte_t       mods;
		logic [47:0] slots;

		for (int i = 0; i < TABLE_DEPTH; i++)
			xlat_table[i] = 16'h0000;
		last_mods  = 8'h00;
		last_slots = '0;

		// Directed: escapes, break bit already set, unmapped keys, duplicates
		push_load(8'h04, 16'h001E);
		push_load(8'h05, 16'h0030);
		push_load(8'hE0, 16'h001D);
		push_load(8'hE7, 16'hE05C);
		push_load(8'h48, 16'hE1C5);
		push_load(8'hFF, 16'hFFFF);
		push_load(8'h00, 16'hFFFF);
		push_report(8'hFF, {8'h07, 8'h06, 8'hFF, 8'h48, 8'h05, 8'h04});
		push_report(8'hFF, {8'h07, 8'h06, 8'hFF, 8'h48, 8'h05, 8'h04});
		// Junk after the terminating zero is stored but not listed
		push_report(8'h00, {8'h00, 8'h00, 8'h05, 8'h00, 8'h04, 8'h04});
		// Key held twice before, released twice
		push_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00});
		push_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h04, 8'h04, 8'h04});
		// Release of a key whose entry was cleared while held
		push_load(8'h04, 16'h0000);
		push_report(8'h00, 48'h0);
		push_load(8'h04, 16'h001E);

		// Map modifiers and low keys with escape and clear break bit
		for (int i = 0; i < NUM_MODS; i++)
			push_load(MOD_BASE + byte_t'(i),
				{8'($urandom_range(1, 255)), 1'b0, 7'($urandom)});
		for (int i = 4; i < 16; i++)
			push_load(byte_t'(i), {8'($urandom_range(1, 255)), 1'b0, 7'($urandom)});
		// Full swap of every key: the longest byte burst
		push_report(8'h0F, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
		push_report(8'hF0, {8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A});

		// Random: mostly typing sequences, some loads and noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				push_load(($urandom_range(0, 1) == 0) ? pick_key() : byte_t'($urandom),
					($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
			end else if (r < 22) begin
				slots = {16'($urandom), 32'($urandom)};
				if ($urandom_range(0, 1) == 0)
					slots[$urandom_range(0, NUM_SLOTS - 1)*8 +: 8] = 8'h00;
				push_report(byte_t'($urandom), slots);
			end else if (r < 30) begin
				push_report(gen_mods, gen_slots);
			end else if (r < 45) begin
				slots = gen_slots;
				slots[$urandom_range(0, NUM_SLOTS - 1)*8 +: 8] = pick_key();
				mods = gen_mods ^ byte_t'(1 << $urandom_range(0, NUM_MODS - 1));
				push_report(mods, slots);
			end else begin
				n = $urandom_range(0, NUM_SLOTS);
				slots = '0;
				for (int j = 0; j < n; j++)
					slots[j*8 +: 8] = pick_key();
				if (n < NUM_SLOTS && $urandom_range(0, 9) == 0)
					slots[47 -: 8] = 8'($urandom_range(1, 255));
				push_report(byte_t'($urandom & $urandom), slots);
			end
		end

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (hid_items_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (xt_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d table loads and %0d reports, %0d scan bytes compared",
			load_count, rep_count, out_count);
		$display("receiver held off %0d cycles once; %0d mismatches", HOLD_CYCLES, err_count);
		if (err_count == 0 && xt_bytes_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
src/hxs_pkg.sv
src/hxs_ctrl.sv
src/hxs_datapath.sv
src/hid_report_to_xt_scancodes.sv
src/hxs_checker.sv
tb/tb_hid_report_to_xt_scancodes.sv
